// ===== src/rcti_pkg.sv =====
// Shared constants for the rounded corner text inset unit.
// Register indexes, inset mode codes and the constant divide by twenty.
// No dependencies.
package rcti_pkg;

  localparam int COORD_BITS_DEF = 14;
  localparam int DFLT_DIV       = 20;
  localparam int CFG_IDX_W      = 3;

  localparam logic [CFG_IDX_W-1:0] REG_SURF_W = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_SURF_H = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_RAD_TL = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_RAD_BL = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_RAD_TR = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_RAD_BR = 3'd5;
  localparam logic [CFG_IDX_W-1:0] REG_MODE   = 3'd6;

  localparam logic [1:0] MODE_OFF  = 2'd0;
  localparam logic [1:0] MODE_HALF = 2'd1;

  // floor(x / 20) for x below 2^16: floor(floor(x / 4) / 5) by reciprocal
  localparam logic [31:0] RECIP5     = 32'd52429;
  localparam int          RECIP5_SHR = 18;

  function automatic logic [15:0] div20(input logic [15:0] x);
    logic [31:0] p;
    p = 32'(x[15:2]) * RECIP5;
    return 16'(p >> RECIP5_SHR);
  endfunction

endpackage

// ===== src/rounded_corner_text_inset_unit.sv =====
// Rounded corner text inset unit: top level, configuration and output stage.
// Depends on rcti_pkg and rcti_corner.
//
// A request names a side, the canvas size and a text row; the result is the
// horizontal inset that keeps the row clear of that side's rounded corners.
// Input and result channels use valid/stall; one result per request, in order.
// Configuration writes go through cfg_valid/cfg_ready with cfg_index and
// cfg_data; cfg_ready is always high and unused indexes are dropped.
// Write configuration only while no request is in flight.
// Throughput: one request per cycle while no result waits under out_stall.
// The pipeline holds the extent divider (2*COORD_BITS+2 stages), the arc
// square root (RW+1 stages, RW = ceil((3*COORD_BITS+3)/2)) and the final
// ratio divider (COORD_BITS+3 stages).
// Both corners of a side run in parallel lanes.
// Reset clears all valid bits and sets every configuration register to 0 (inset off).
// When the receiver stalls with a result waiting, the whole pipeline holds
// and in_stall rises in the same cycle; nothing is lost or repeated.
module rounded_corner_text_inset_unit
  import rcti_pkg::*;
#(
  parameter int COORD_BITS = COORD_BITS_DEF
) (
  input  logic                    clk,
  input  logic                    rst_n,
  input  logic                    in_valid,
  output logic                    in_stall,
  input  logic                    in_opcode,
  input  logic [COORD_BITS-1:0]   in_canvas_width,
  input  logic [COORD_BITS-1:0]   in_canvas_height,
  input  logic signed [COORD_BITS:0] in_row_top,
  input  logic signed [COORD_BITS:0] in_row_height,
  output logic                    out_valid,
  input  logic                    out_stall,
  output logic [COORD_BITS-1:0]   out_inset,
  input  logic                    cfg_valid,
  output logic                    cfg_ready,
  input  logic [CFG_IDX_W-1:0]    cfg_index,
  input  logic [COORD_BITS-1:0]   cfg_data
);

  localparam int CB   = COORD_BITS;
  localparam int DEPW = CB + 3;
  localparam int QW   = CB + 2;

  logic [CB-1:0] sw_r, sh_r, rtl_r, rbl_r, rtr_r, rbr_r;
  logic [1:0]    mode_r;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sw_r   <= '0;
      sh_r   <= '0;
      rtl_r  <= '0;
      rbl_r  <= '0;
      rtr_r  <= '0;
      rbr_r  <= '0;
      mode_r <= MODE_OFF;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        REG_SURF_W: sw_r   <= cfg_data;
        REG_SURF_H: sh_r   <= cfg_data;
        REG_RAD_TL: rtl_r  <= cfg_data;
        REG_RAD_BL: rbl_r  <= cfg_data;
        REG_RAD_TR: rtr_r  <= cfg_data;
        REG_RAD_BR: rbr_r  <= cfg_data;
        REG_MODE:   mode_r <= cfg_data[1:0];
        default: ;
      endcase
    end
  end

  logic en;
  assign en       = !out_valid || !out_stall;
  assign in_stall = !en;

  // entry stage: pick the side, apply the default radius, form the depths
  logic [CB-1:0]         dflt, rt_sel, rb_sel, rt_eff, rb_eff;
  logic signed [DEPW-1:0] y_s, h_s, db;

  assign dflt   = CB'(div20(16'(sw_r)));
  assign rt_sel = in_opcode ? rtr_r : rtl_r;
  assign rb_sel = in_opcode ? rbr_r : rbl_r;
  assign rt_eff = (rt_sel == '0 && sw_r != '0) ? dflt : rt_sel;
  assign rb_eff = (rb_sel == '0 && sw_r != '0) ? dflt : rb_sel;
  assign y_s    = DEPW'(in_row_top);
  assign h_s    = (in_row_height <= 0) ? DEPW'(1) : DEPW'(in_row_height);
  assign db     = signed'(DEPW'(in_canvas_height)) - (y_s + h_s);

  logic [CB-1:0]          cw_r, ch_r, rt_r, rb_r;
  logic signed [DEPW-1:0] dt_r, db_r;
  logic                   kill_r, vld0_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld0_r <= 1'b0;
    end else if (en) begin
      vld0_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      cw_r   <= in_canvas_width;
      ch_r   <= in_canvas_height;
      rt_r   <= rt_eff;
      rb_r   <= rb_eff;
      dt_r   <= y_s;
      db_r   <= db;
      kill_r <= (in_canvas_width == '0) || (in_canvas_height == '0);
    end
  end

  logic          vt, vb;
  logic [QW-1:0] a, b;

  rcti_corner #(.CB(CB)) u_top (
    .clk, .rst_n, .en,
    .in_vld (vld0_r),
    .in_cw  (cw_r),
    .in_ch  (ch_r),
    .in_rad (rt_r),
    .in_dep (dt_r),
    .in_kill(kill_r),
    .sw     (sw_r),
    .sh     (sh_r),
    .out_vld(vt),
    .out_ins(a)
  );

  rcti_corner #(.CB(CB)) u_bot (
    .clk, .rst_n, .en,
    .in_vld (vld0_r),
    .in_cw  (cw_r),
    .in_ch  (ch_r),
    .in_rad (rb_r),
    .in_dep (db_r),
    .in_kill(kill_r),
    .sw     (sw_r),
    .sh     (sh_r),
    .out_vld(vb),
    .out_ins(b)
  );

  // output stage: larger corner, mode, saturation
  logic [QW-1:0] mx;
  logic [QW:0]   half, sel;
  logic [CB-1:0] res;

  assign mx   = (b > a) ? b : a;
  assign half = ((QW+1)'(mx) + (QW+1)'(1)) >> 1;
  assign sel  = (mode_r == MODE_HALF) ? half : (QW+1)'(mx);
  assign res  = (mode_r == MODE_OFF) ? '0 :
                (sel > (QW+1)'({CB{1'b1}})) ? '1 : sel[CB-1:0];

  logic          out_valid_r;
  logic [CB-1:0] out_inset_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (en) begin
      out_valid_r <= vt && vb;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      out_inset_r <= res;
    end
  end

  assign out_valid = out_valid_r;
  assign out_inset = out_inset_r;

  a_off_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && mode_r == MODE_OFF |-> out_inset == '0)
    else $error("inset nonzero with mode off");

  a_lanes_align: assert property (@(posedge clk) disable iff (!rst_n)
    vt == vb)
    else $error("corner lanes out of step");

  a_hold_in: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |-> in_stall)
    else $error("request taken while result stalled");

  a_rst_clear: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("result valid after reset");

endmodule

// ===== src/rcti_div.sv =====
// Pipelined restoring divider, one quotient bit per stage, with sideband.
// Quotient saturates to all ones when it would not fit in QW bits.
// No dependencies.
module rcti_div #(
  parameter int NW  = 29,
  parameter int DW  = 14,
  parameter int QW  = 29,
  parameter int SBW = 1
) (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           en,
  input  logic           in_vld,
  input  logic [NW-1:0]  in_num,
  input  logic [DW-1:0]  in_den,
  input  logic [SBW-1:0] in_sb,
  output logic           out_vld,
  output logic [QW-1:0]  out_quo,
  output logic [SBW-1:0] out_sb
);

  logic [DW-1:0]  rem_r [0:QW];
  logic [QW-1:0]  nq_r  [0:QW];
  logic [DW-1:0]  den_r [0:QW];
  logic [SBW-1:0] sb_r  [0:QW];
  logic [QW:0]    ovf_r;
  logic [QW:0]    vld_r;

  logic          ovf;
  logic [DW-1:0] rem0;

  generate
    if (QW < NW) begin : g_hi
      logic [NW-QW-1:0] hi;
      assign hi   = in_num[NW-1:QW];
      assign ovf  = (hi >= in_den);
      assign rem0 = DW'(hi);
    end else begin : g_nohi
      assign ovf  = 1'b0;
      assign rem0 = '0;
    end
  endgenerate

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r[0] <= 1'b0;
    end else if (en) begin
      vld_r[0] <= in_vld;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      rem_r[0] <= rem0;
      nq_r[0]  <= in_num[QW-1:0];
      den_r[0] <= in_den;
      sb_r[0]  <= in_sb;
      ovf_r[0] <= ovf;
    end
  end

  genvar k;
  generate
    for (k = 0; k < QW; k++) begin : g_stg
      logic [DW:0]   trial;
      logic          ge;
      logic [DW:0]   diff;
      logic [DW-1:0] rem_nxt;

      assign trial   = {rem_r[k], nq_r[k][QW-1]};
      assign diff    = trial - {1'b0, den_r[k]};
      assign ge      = (trial >= {1'b0, den_r[k]});
      assign rem_nxt = ge ? diff[DW-1:0] : trial[DW-1:0];

      always_ff @(posedge clk) begin
        if (!rst_n) begin
          vld_r[k+1] <= 1'b0;
        end else if (en) begin
          vld_r[k+1] <= vld_r[k];
        end
      end

      always_ff @(posedge clk) begin
        if (en) begin
          rem_r[k+1] <= rem_nxt;
          nq_r[k+1]  <= {nq_r[k][QW-2:0], ge};
          den_r[k+1] <= den_r[k];
          sb_r[k+1]  <= sb_r[k];
          ovf_r[k+1] <= ovf_r[k];
        end
      end
    end
  endgenerate

  assign out_vld = vld_r[QW];
  assign out_quo = ovf_r[QW] ? '1 : nq_r[QW];
  assign out_sb  = sb_r[QW];

endmodule

// ===== src/rcti_sqrt.sv =====
// Pipelined integer square root, one result bit per stage, with sideband.
// AW must be even; the root has AW/2 bits.
// No dependencies.
module rcti_sqrt #(
  parameter int AW  = 46,
  parameter int SBW = 1
) (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            en,
  input  logic            in_vld,
  input  logic [AW-1:0]   in_arg,
  input  logic [SBW-1:0]  in_sb,
  output logic            out_vld,
  output logic [AW/2-1:0] out_root,
  output logic [SBW-1:0]  out_sb
);

  localparam int RW   = AW / 2;
  localparam int REMW = RW + 2;

  logic [REMW-1:0] rem_r  [0:RW];
  logic [RW-1:0]   root_r [0:RW];
  logic [AW-1:0]   arg_r  [0:RW];
  logic [SBW-1:0]  sb_r   [0:RW];
  logic [RW:0]     vld_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r[0] <= 1'b0;
    end else if (en) begin
      vld_r[0] <= in_vld;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      rem_r[0]  <= '0;
      root_r[0] <= '0;
      arg_r[0]  <= in_arg;
      sb_r[0]   <= in_sb;
    end
  end

  genvar k;
  generate
    for (k = 0; k < RW; k++) begin : g_stg
      logic [REMW:0]   shf;
      logic [REMW:0]   trial;
      logic [REMW:0]   diff;
      logic            ge;

      assign shf   = {rem_r[k][REMW-2:0], arg_r[k][AW-1:AW-2]};
      assign trial = (REMW+1)'({root_r[k], 2'b01});
      assign diff  = shf - trial;
      assign ge    = (shf >= trial);

      always_ff @(posedge clk) begin
        if (!rst_n) begin
          vld_r[k+1] <= 1'b0;
        end else if (en) begin
          vld_r[k+1] <= vld_r[k];
        end
      end

      always_ff @(posedge clk) begin
        if (en) begin
          rem_r[k+1]  <= ge ? diff[REMW-1:0] : shf[REMW-1:0];
          root_r[k+1] <= {root_r[k][RW-2:0], ge};
          arg_r[k+1]  <= {arg_r[k][AW-3:0], 2'b00};
          sb_r[k+1]   <= sb_r[k];
        end
      end
    end
  endgenerate

  assign out_vld  = vld_r[RW];
  assign out_root = root_r[RW];
  assign out_sb   = sb_r[RW];

endmodule

// ===== src/rcti_corner.sv =====
// One corner of the inset: scaled extents, arc square root, rounded ratio.
// Depends on rcti_pkg, rcti_div and rcti_sqrt.
module rcti_corner
  import rcti_pkg::*;
#(
  parameter int CB = COORD_BITS_DEF
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                en,
  input  logic                in_vld,
  input  logic [CB-1:0]       in_cw,
  input  logic [CB-1:0]       in_ch,
  input  logic [CB-1:0]       in_rad,
  input  logic signed [CB+2:0] in_dep,
  input  logic                in_kill,
  input  logic [CB-1:0]       sw,
  input  logic [CB-1:0]       sh,
  output logic                out_vld,
  output logic [CB+1:0]       out_ins
);

  localparam int W2   = 2 * CB;
  localparam int DEPW = CB + 3;
  localparam int NW1  = 2 * CB + 1;
  localparam int QW   = CB + 2;
  localparam int AW0  = 3 * CB + 3;
  localparam int AW   = AW0 + (AW0 % 2);
  localparam int RW   = AW / 2;
  localparam int NW3  = 2 * W2 + 1;
  localparam int SBS  = 2 * W2 + 3;

  // extents
  logic           fbx, fby;
  logic [W2-1:0]  px, py;
  logic [NW1-1:0] nx, ny;
  logic [CB-1:0]  dx, dy;

  assign fbx = (in_rad == '0) || (sw == '0);
  assign fby = (in_rad == '0) || (sh == '0);
  assign px  = W2'(in_rad) * W2'(in_cw);
  assign py  = W2'(in_rad) * W2'(in_ch);
  assign nx  = fbx ? NW1'(in_cw) : NW1'(px) + NW1'(sw >> 1);
  assign ny  = fby ? NW1'(in_cw) : NW1'(py) + NW1'(sh >> 1);
  assign dx  = fbx ? CB'(DFLT_DIV) : sw;
  assign dy  = fby ? CB'(DFLT_DIV) : sh;

  logic           vx, vy;
  logic [NW1-1:0] qx, qy;
  logic [DEPW:0]  sbx;
  logic [0:0]     sby;

  rcti_div #(.NW(NW1), .DW(CB), .QW(NW1), .SBW(DEPW + 1)) u_divx (
    .clk, .rst_n, .en,
    .in_vld (in_vld),
    .in_num (nx),
    .in_den (dx),
    .in_sb  ({in_kill, in_dep}),
    .out_vld(vx),
    .out_quo(qx),
    .out_sb (sbx)
  );

  rcti_div #(.NW(NW1), .DW(CB), .QW(NW1), .SBW(1)) u_divy (
    .clk, .rst_n, .en,
    .in_vld (in_vld),
    .in_num (ny),
    .in_den (dy),
    .in_sb  (in_dep <= 0),
    .out_vld(vy),
    .out_quo(qy),
    .out_sb (sby)
  );

  // arc argument d * (2 * yr - d)
  logic [W2-1:0]         xe, yr;
  logic signed [DEPW-1:0] dep;
  logic [CB+1:0]         d;
  logic [W2:0]           tmy;
  logic [AW0-1:0]        prod;
  logic                  zero_a, le0_a, beyond_a;

  assign xe       = qx[W2-1:0];
  assign yr       = qy[W2-1:0];
  assign dep      = signed'(sbx[DEPW-1:0]);
  assign d        = dep[DEPW-2:0];
  assign tmy      = {yr, 1'b0} - (W2+1)'(d);
  assign prod     = AW0'(d) * AW0'(tmy);
  assign le0_a    = sby[0];
  assign beyond_a = (d >= yr);
  assign zero_a   = sbx[DEPW] || (xe == '0) || (yr == '0);

  logic           vs;
  logic [RW-1:0]  root;
  logic [SBS-1:0] sbs;

  rcti_sqrt #(.AW(AW), .SBW(SBS)) u_sqrt (
    .clk, .rst_n, .en,
    .in_vld  (vx && vy),
    .in_arg  (AW'(prod)),
    .in_sb   ({xe, yr, zero_a, le0_a, beyond_a}),
    .out_vld (vs),
    .out_root(root),
    .out_sb  (sbs)
  );

  // xe * (yr - root) in two partial products, then add the rounding term
  logic [W2-1:0]    xe_s, yr_s, m;
  logic [QW-1:0]    xsat;
  logic [W2+CB-1:0] phi_r, plo_r;
  logic [W2-1:0]    yr1_r, yr2_r;
  logic [2:0]       fl1_r, fl2_r;
  logic [QW-1:0]    xs1_r, xs2_r;
  logic             vld1_r, vld2_r;
  logic [NW3-1:0]   num_r;

  assign xe_s = sbs[SBS-1 -: W2];
  assign yr_s = sbs[SBS-1-W2 -: W2];
  assign m    = yr_s - W2'(root);
  assign xsat = (xe_s > W2'({QW{1'b1}})) ? '1 : xe_s[QW-1:0];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld1_r <= 1'b0;
      vld2_r <= 1'b0;
    end else if (en) begin
      vld1_r <= vs;
      vld2_r <= vld1_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      phi_r <= (W2+CB)'(xe_s[W2-1:CB]) * (W2+CB)'(m);
      plo_r <= (W2+CB)'(xe_s[CB-1:0]) * (W2+CB)'(m);
      yr1_r <= yr_s;
      fl1_r <= sbs[2:0];
      xs1_r <= xsat;
      num_r <= (NW3'(phi_r) << CB) + NW3'(plo_r) + NW3'(yr1_r >> 1);
      yr2_r <= yr1_r;
      fl2_r <= fl1_r;
      xs2_r <= xs1_r;
    end
  end

  logic          vq;
  logic [QW-1:0] q;
  logic [QW+2:0] sbq;
  logic [QW-1:0] xs_q;
  logic          zero_q, le0_q, beyond_q;

  rcti_div #(.NW(NW3), .DW(W2), .QW(QW), .SBW(QW + 3)) u_divq (
    .clk, .rst_n, .en,
    .in_vld (vld2_r),
    .in_num (num_r),
    .in_den (yr2_r),
    .in_sb  ({xs2_r, fl2_r}),
    .out_vld(vq),
    .out_quo(q),
    .out_sb (sbq)
  );

  assign {xs_q, zero_q, le0_q, beyond_q} = sbq;

  assign out_vld = vq;
  assign out_ins = zero_q ? '0 : le0_q ? xs_q : beyond_q ? '0 : q;

endmodule

// ===== dv/testbench.sv =====
// Testbench for the rounded corner text inset unit: directed table, then random requests
// checked against a behavioral predictor, under three idling phases and several configurations.
// Depends on rcti_pkg and rounded_corner_text_inset_unit.
module testbench;
  import rcti_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int CB = COORD_BITS_DEF;
  localparam longint CMAX = (64'd1 << CB) - 1;
  localparam int LATENCY = 76;

  logic clk = 0, rst_n = 0;
  logic in_valid = 0, in_stall, in_opcode = 0;
  logic [CB-1:0] in_canvas_width = 0, in_canvas_height = 0;
  logic signed [CB:0] in_row_top = 0, in_row_height = 0;
  logic out_valid, out_stall = 0;
  logic [CB-1:0] out_inset;
  logic cfg_valid = 0, cfg_ready;
  logic [CFG_IDX_W-1:0] cfg_index = 0;
  logic [CB-1:0] cfg_data = 0;

  rounded_corner_text_inset_unit u_top (.*);

  typedef struct packed {
    logic opc;
    logic [CB-1:0] cw, ch;
    logic signed [CB:0] top, hgt;
  } query_t;

  typedef struct {
    query_t q;
    int want;  // -1: use predictor
  } row_t;

  longint unsigned regs[7];
  logic [CB-1:0] inset_q[$];
  int errors = 0, snd_idle = 14, rcv_idle = 76;
  longint cycles = 0;

  initial forever #5 clk = ~clk;

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > 3000000) begin
      $display("DONE: errors detected");
      $finish;
    end
  end

  function automatic longint unsigned isqrt(longint unsigned v);
    longint unsigned root = 0, b = 64'd1 << 62;
    while (b > v) b >>= 2;
    while (b != 0) begin
      if (v >= root + b) begin
        v -= root + b;
        root = (root >> 1) + b;
      end else root >>= 1;
      b >>= 2;
    end
    return root;
  endfunction

  function automatic longint unsigned ext_x(longint unsigned cw, longint unsigned r);
    longint unsigned sw = regs[REG_SURF_W];
    if (r == 0 && sw > 0) r = sw / DFLT_DIV;
    if (r == 0 || sw == 0) return cw / DFLT_DIV;
    return (r * cw + sw / 2) / sw;
  endfunction

  function automatic longint unsigned ext_y(longint unsigned cw, longint unsigned ch,
                                            longint unsigned r);
    longint unsigned sh = regs[REG_SURF_H];
    if (r == 0 && regs[REG_SURF_W] > 0) r = regs[REG_SURF_W] / DFLT_DIV;
    if (r == 0 || sh == 0) return cw / DFLT_DIV;
    return (r * ch + sh / 2) / sh;
  endfunction

  function automatic longint unsigned arc(longint unsigned xe, longint unsigned yr,
                                          longint depth);
    longint unsigned dy, rt;
    if (xe == 0 || yr == 0) return 0;
    if (depth <= 0) return xe;
    if (longint'(depth) >= longint'(yr)) return 0;
    dy = yr - depth;
    rt = isqrt(yr * yr - dy * dy);
    return (xe * (yr - rt) + yr / 2) / yr;
  endfunction

  function automatic logic [CB-1:0] corner_inset(query_t q);
    longint unsigned cw = q.cw, ch = q.ch, tr, br, a, b, res = 0;
    longint y = q.top, h = q.hgt;
    tr = q.opc ? regs[REG_RAD_TR] : regs[REG_RAD_TL];
    br = q.opc ? regs[REG_RAD_BR] : regs[REG_RAD_BL];
    if (regs[REG_MODE] != MODE_OFF && cw != 0 && ch != 0) begin
      if (h <= 0) h = 1;
      a = arc(ext_x(cw, tr), ext_y(cw, ch, tr), y);
      b = arc(ext_x(cw, br), ext_y(cw, ch, br), longint'(ch) - (y + h));
      res = b > a ? b : a;
      if (regs[REG_MODE] == MODE_HALF) res = (res + 1) / 2;
      if (res > CMAX) res = CMAX;
    end
    return res[CB-1:0];
  endfunction

  task automatic write_reg(int idx, longint unsigned val);
    cfg_valid <= 1;
    cfg_index <= idx[CFG_IDX_W-1:0];
    cfg_data <= val[CB-1:0];
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 0;
    if (idx < 7) regs[idx] = (idx == REG_MODE) ? (val & 3) : (val & CMAX);
    @(posedge clk);
  endtask

  task automatic send(query_t q, int want);
    while ($urandom_range(99) < snd_idle) begin
      in_valid <= 0;
      @(posedge clk);
    end
    {in_opcode, in_canvas_width, in_canvas_height, in_row_top, in_row_height} <= q;
    in_valid <= 1;
    do @(posedge clk); while (in_stall);
    inset_q.push_back(want >= 0 ? want[CB-1:0] : corner_inset(q));
  endtask

  task automatic drain();
    int n = 0;
    in_valid <= 0;
    while (inset_q.size() != 0 && n < 100000) begin
      @(posedge clk);
      n++;
    end
    repeat (LATENCY + 10) @(posedge clk);
  endtask

  function automatic query_t rand_query();
    query_t q;
    q.opc = 1'($urandom_range(1));
    case ($urandom_range(9))
      0: q.cw = 0;
      1: q.cw = CB'(CMAX);
      default: q.cw = CB'($urandom_range(CMAX));
    endcase
    q.ch = ($urandom_range(15) == 0) ? '0 : CB'($urandom_range(CMAX));
    case ($urandom_range(3))
      0: q.top = (CB+1)'($urandom);
      default: q.top = (CB+1)'($urandom_range(q.ch / 4));
    endcase
    case ($urandom_range(3))
      0: q.hgt = (CB+1)'($urandom);
      default: q.hgt = (CB+1)'($urandom_range(200) - 10);
    endcase
    if ($urandom_range(1) && q.ch > 0)
      q.top = (CB+1)'(q.ch - $urandom_range(q.ch / 4) - q.hgt);
    return q;
  endfunction

  always @(posedge clk) begin
    out_stall <= ($urandom_range(99) < rcv_idle);
    if (out_valid && !out_stall) begin
      if (inset_q.size() == 0) begin
        $display("%0t: unexpected inset %0d", $time, out_inset);
        errors++;
      end else begin
        if (out_inset !== inset_q[0]) begin
          $display("%0t: inset expected %0d actual %0d", $time, inset_q[0], out_inset);
          errors++;
        end
        void'(inset_q.pop_front());
      end
    end
  end

  row_t dir[$];

  initial begin
    row_t r;
    foreach (regs[i]) regs[i] = 0;
    repeat (4) @(posedge clk);
    rst_n <= 1;
    @(posedge clk);
    // after reset: mode off
    r.q = '{1'b0, 14'd1000, 14'd1000, 15'sd0, 15'sd10}; r.want = 0; dir.push_back(r);
    r.q = '{1'b1, 14'h3fff, 14'h3fff, -15'sd16384, 15'sd16383}; r.want = 0; dir.push_back(r);
    foreach (dir[i]) send(dir[i].q, dir[i].want);
    drain();
    dir.delete();
    write_reg(REG_MODE, 2);
    // defaults from canvas width: extent 50, row at top gives full extent
    r.q = '{1'b0, 14'd1000, 14'd1000, -15'sd5, 15'sd10}; r.want = 50; dir.push_back(r);
    r.q = '{1'b1, 14'd0, 14'd1000, 15'sd0, 15'sd10}; r.want = 0; dir.push_back(r);
    r.q = '{1'b1, 14'd1000, 14'd0, 15'sd0, 15'sd10}; r.want = 0; dir.push_back(r);
    r.q = '{1'b0, 14'd1000, 14'd1000, 15'sd500, 15'sd10}; r.want = 0; dir.push_back(r);
    r.q = '{1'b0, 14'd19, 14'd100, 15'sd0, 15'sd1}; r.want = 0; dir.push_back(r);
    r.q = '{1'b0, 14'd1000, 14'd1000, 15'sd10, -15'sd16384}; r.want = -1; dir.push_back(r);
    r.q = '{1'b1, 14'd1000, 14'd1000, 15'sd3, 15'sd0}; r.want = -1; dir.push_back(r);
    r.q = '{1'b1, 14'h3fff, 14'h3fff, 15'sd16383, 15'sd16383}; r.want = -1; dir.push_back(r);
    r.q = '{1'b0, 14'd1000, 14'd1000, 15'sd900, 15'sd80}; r.want = -1; dir.push_back(r);
    foreach (dir[i]) send(dir[i].q, dir[i].want);
    drain();
    for (int phase = 0; phase < 8; phase++) begin
      if (phase == 3) begin snd_idle = 76; rcv_idle = 14; end
      if (phase == 6) begin snd_idle = 0; rcv_idle = 0; end
      case (phase)
        0: begin
          write_reg(REG_SURF_W, CMAX); write_reg(REG_SURF_H, CMAX);
          for (int k = REG_RAD_TL; k <= REG_RAD_BR; k++) write_reg(k, CMAX);
          write_reg(REG_MODE, 3);
        end
        1: begin
          write_reg(REG_SURF_W, 1); write_reg(REG_SURF_H, 1);
          for (int k = REG_RAD_TL; k <= REG_RAD_BR; k++) write_reg(k, 0);
          write_reg(REG_MODE, 1); write_reg(7, 5);
        end
        2: begin
          write_reg(REG_SURF_W, 0); write_reg(REG_SURF_H, 0);
          write_reg(REG_RAD_TL, 300); write_reg(REG_MODE, 2);
        end
        default: begin
          for (int k = REG_SURF_W; k <= REG_RAD_BR; k++)
            write_reg(k, ($urandom_range(3) == 0) ? 0 : $urandom_range(CMAX));
          write_reg(REG_MODE, $urandom_range(3));
        end
      endcase
      repeat (215) send(rand_query(), -1);
      drain();
    end
    if (errors == 0) $display("DONE: 0 errors");
    else $display("DONE: errors detected");
    $finish;
  end
endmodule

// ===== files.f =====
src/rcti_pkg.sv
src/rcti_div.sv
src/rcti_sqrt.sv
src/rcti_corner.sv
src/rounded_corner_text_inset_unit.sv
dv/testbench.sv
